// ----- hw/rtl/rsrk_pkg.sv -----
// rsrk_pkg: shared types and widths of the rank sort block
// no dependencies; used by the interfaces, the sort cells and the top level

package rsrk_pkg;

  localparam int KEY_W = 24;
  localparam int PAY_W = 32;

  // one stored record as it moves along the chain
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } rec_t;

  // per-cycle command broadcast from the top level to every cell
  typedef struct packed {
    logic ins;    // insert the incoming record into the sorted row
    logic shift;  // drain: every cell takes its upper neighbor's record
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/rsrk_if.sv -----
// rsrk_in_if / rsrk_out_if: valid/ready channels of the rank sort block
// depends on rsrk_pkg for the field widths

interface rsrk_in_if;
  import rsrk_pkg::*;

  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] in_key;
  logic [PAY_W-1:0] in_payload;
  logic             in_last;

  modport source (output valid, output in_key, output in_payload, output in_last,
                  input ready);
  modport sink   (input valid, input in_key, input in_payload, input in_last,
                  output ready);
endinterface

interface rsrk_out_if;
  import rsrk_pkg::*;

  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] out_key;
  logic [PAY_W-1:0] out_payload;
  logic             out_last;
  logic             out_overflow;

  modport source (output valid, output out_key, output out_payload, output out_last,
                  output out_overflow, input ready);
  modport sink   (input valid, input out_key, input out_payload, input out_last,
                  input out_overflow, output ready);
endinterface

// ----- hw/rtl/rank_sort_records_by_key_top.sv -----
// rank_sort_records_by_key_top: usage notes
// Input channel rec (rsrk_in_if, sink): one record per transfer, a 24-bit key
// and a 32-bit payload; in_last closes the batch. Output channel sorted
// (rsrk_out_if, source): the stored records in ascending key order, equal
// keys in arrival order, out_last on the final one, out_overflow set on every
// record of a run whose batch lost records to a full store.
// Records are held in a row of MAX_RECORDS cells kept sorted at all times: a
// record is placed by a broadcast compare, so loading takes one record per
// cycle with ready high. Up to MAX_RECORDS records are kept; later ones are
// dropped and flag overflow.
// The cycle after the in_last transfer the first sorted record is valid; the
// run drains by shifting the row one cell toward the head per transfer. While
// the run drains rec.ready is low; it rises the cycle after the out_last
// transfer. A stall on the output simply holds the row. Reset (rst,
// synchronous) clears the fill count, the overflow flag and the drain state;
// cell contents are not cleared, since only filled cells are ever read.

module rank_sort_records_by_key_top #(
  parameter int MAX_RECORDS = 64
) (
  input  logic clk,
  input  logic rst,
  rsrk_in_if.sink    rec,
  rsrk_out_if.source sorted
);
  import rsrk_pkg::*;

  localparam int CNT_W = $clog2(MAX_RECORDS + 1);

  logic [CNT_W-1:0] count;
  logic             overflow;
  logic             draining;

  logic       in_xfer;
  logic       out_xfer;
  logic       full;
  cell_ctrl_t ctrl;
  rec_t       new_rec;
  rec_t       cell_rec [MAX_RECORDS];
  logic       cell_gt  [MAX_RECORDS];

  assign rec.ready = !draining;
  assign in_xfer   = rec.valid && rec.ready;
  assign out_xfer  = sorted.valid && sorted.ready;
  assign full      = (count == CNT_W'(MAX_RECORDS));

  assign new_rec.key     = rec.in_key;
  assign new_rec.payload = rec.in_payload;

  assign ctrl.ins   = in_xfer && !full;
  assign ctrl.shift = out_xfer;

  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    rec_t lower_rec;
    logic lower_gt;
    rec_t upper_rec;

    if (i == 0) begin : g_head
      assign lower_rec = new_rec;
      assign lower_gt  = 1'b0;
    end else begin : g_mid
      assign lower_rec = cell_rec[i-1];
      assign lower_gt  = cell_gt[i-1];
    end

    if (i == MAX_RECORDS - 1) begin : g_tail
      assign upper_rec = cell_rec[i];
    end else begin : g_body
      assign upper_rec = cell_rec[i+1];
    end

    rsrk_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occupied  (count > CNT_W'(i)),
      .new_rec   (new_rec),
      .lower_rec (lower_rec),
      .lower_gt  (lower_gt),
      .upper_rec (upper_rec),
      .rec       (cell_rec[i]),
      .gt        (cell_gt[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      overflow <= 1'b0;
      draining <= 1'b0;
    end else if (in_xfer) begin
      if (full) begin
        overflow <= 1'b1;
      end else begin
        count <= count + CNT_W'(1);
      end
      if (rec.in_last) begin
        draining <= 1'b1;
      end
    end else if (out_xfer) begin
      if (count == CNT_W'(1)) begin
        // end of run: batch state returns to empty
        draining <= 1'b0;
        count    <= '0;
        overflow <= 1'b0;
      end else begin
        count <= count - CNT_W'(1);
      end
    end
  end

  assign sorted.valid        = draining;
  assign sorted.out_key      = cell_rec[0].key;
  assign sorted.out_payload  = cell_rec[0].payload;
  assign sorted.out_last     = (count == CNT_W'(1));
  assign sorted.out_overflow = overflow;

endmodule

// ----- hw/rtl/rsrk_cell.sv -----
// rsrk_cell: one slot of the insertion-sort chain, holds one record
// depends on rsrk_pkg; instantiated in a row by the top level

module rsrk_cell (
  input  logic               clk,
  input  rsrk_pkg::cell_ctrl_t ctrl,
  input  logic               occupied,  // slot holds a record of this batch
  input  rsrk_pkg::rec_t     new_rec,   // record being inserted, broadcast
  input  rsrk_pkg::rec_t     lower_rec, // neighbor closer to the head
  input  logic               lower_gt,  // new record lands at or below the neighbor
  input  rsrk_pkg::rec_t     upper_rec, // neighbor farther from the head
  output rsrk_pkg::rec_t     rec,
  output logic               gt
);
  import rsrk_pkg::*;

  // new record goes before this slot; equal keys stay behind the stored one
  assign gt = !occupied || (new_rec.key < rec.key);

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      rec <= upper_rec;
    end else if (ctrl.ins) begin
      if (lower_gt) begin
        rec <= lower_rec;
      end else if (gt) begin
        rec <= new_rec;
      end
    end
  end

endmodule

// ----- hw/rtl/rsrk_checker.sv -----
// rsrk_checker: port-level properties of the rank sort block
// bound to rank_sort_records_by_key_top; uses only its channel ports

module rsrk_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic in_last,
  input logic out_valid,
  input logic out_ready,
  input logic out_last,
  input logic out_overflow
);

  // loading and draining never overlap
  a_no_load_while_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready while a sorted run is pending");

  // a closing transfer starts the output run in the next cycle
  a_run_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_last) |=> out_valid)
    else $error("no output after the final record of a batch");

  // a run has no gaps until its last record
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !out_last) |=> out_valid)
    else $error("output run ended before out_last");

  // the run ends right after out_last and loading resumes
  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_last) |=> (!out_valid && in_ready))
    else $error("output still valid after out_last");

  // overflow is one value for the whole run
  a_ovf_steady: assert property (@(posedge clk) disable iff (rst)
    (out_valid && $past(out_valid)) |-> (out_overflow == $past(out_overflow)))
    else $error("overflow flag changed within a run");

endmodule

bind rank_sort_records_by_key_top rsrk_checker u_rsrk_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (rec.valid),
  .in_ready     (rec.ready),
  .in_last      (rec.in_last),
  .out_valid    (sorted.valid),
  .out_ready    (sorted.ready),
  .out_last     (sorted.out_last),
  .out_overflow (sorted.out_overflow)
);
